[src/mlse_pkg.sv]
// Shared types and codes for the multi-list store engine.
`default_nettype none

package mlse_pkg;

  // Operation codes of an input word.
  typedef enum logic [2:0] {
    OP_CREATE      = 3'd0,
    OP_APPEND      = 3'd1,
    OP_POP         = 3'd2,
    OP_REMOVE      = 3'd3,
    OP_READ        = 3'd4,
    OP_READ_SORTED = 3'd5
  } op_e;

  // Status codes of a result word.
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_POS   = 4'd1,
    ST_BAD_SIZE  = 4'd2,
    ST_EXISTS    = 4'd3,
    ST_NONE      = 4'd4,
    ST_FULL      = 4'd5,
    ST_EMPTY     = 4'd6,
    ST_NOT_FOUND = 4'd7,
    ST_NO_MEM    = 4'd8
  } st_e;

  // What the held input word needs after the checks.
  typedef enum logic [2:0] {
    KIND_SKIP,
    KIND_SINGLE,
    KIND_REMOVE,
    KIND_READ,
    KIND_SORT
  } kind_e;

  // Source of an emitted result word.
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_CODE,
    EMIT_ELEM,
    EMIT_BEST
  } emit_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         list_number;
    logic signed [31:0] value;
    logic [15:0]        size;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [31:0] data;
    logic               has_data;
    logic               last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  latch;
    logic  commit;
    logic  idx_clr;
    logic  idx_inc;
    logic  pass_clr;
    logic  pass_inc;
    logic  mem_rd;
    logic  shift_wr;
    logic  dec_fill;
    logic  best_clr;
    logic  best_eval;
    logic  prev_upd;
    emit_e emit;
    st_e   code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    st_e   code;
    logic  idx_last;
    logic  pass_last;
    logic  match;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

[src/mlse_dp.sv]
// Datapath: list tables, element memory, walk counters, sort tracking and output register.
`default_nettype none

module mlse_dp #(
  parameter int NUM_LISTS = 10,
  parameter int MAX_DEPTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mlse_pkg::in_word_t  in_word_i,
  input  mlse_pkg::cmd_t      cmd_i,
  output mlse_pkg::sts_t      sts_o,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output mlse_pkg::out_word_t out_word_o
);

  localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CW    = $clog2(MAX_DEPTH + 1);
  localparam int IW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DEPTH = NUM_LISTS * MAX_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mlse_pkg::in_word_t item_q;

  logic          exists_q [NUM_LISTS];
  logic [CW-1:0] cap_q    [NUM_LISTS];
  logic [CW-1:0] fill_q   [NUM_LISTS];

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] mem_q;

  logic [IW-1:0]      idx_q, pass_q;
  logic signed [31:0] best_v_q, prev_v_q;
  logic [IW-1:0]      prev_i_q, best_i_q;
  logic               found_q, have_prev_q;

  logic               out_valid_q;
  mlse_pkg::out_word_t out_q;

  logic [LW-1:0] li;
  logic          num_ok, cur_exists;
  logic [CW-1:0] cnt, cap;
  logic [AW-1:0] base, rd_addr, app_addr, sh_addr, wr_addr;
  logic signed [31:0] wr_data;
  logic          wr_en, commit_ok, idx_last, pass_last, out_free;
  logic          cand_gt, cand_lt;
  mlse_pkg::kind_e kind;
  mlse_pkg::st_e   code;

  // Decode of the held word against the list tables.
  assign li         = LW'(item_q.list_number - 4'd1);
  assign num_ok     = (item_q.list_number != 4'd0) && (item_q.list_number <= 4'(NUM_LISTS));
  assign cur_exists = exists_q[li];
  assign cnt        = fill_q[li];
  assign cap        = cap_q[li];

  assign base     = AW'(li) * AW'(MAX_DEPTH);
  assign rd_addr  = base + AW'(idx_q);
  assign app_addr = base + AW'(cnt);
  assign sh_addr  = base + AW'(idx_q) - AW'(1);

  // Checks in the order that the status codes take priority.
  always_comb begin
    kind = mlse_pkg::KIND_SINGLE;
    code = mlse_pkg::ST_OK;
    if (item_q.op > 3'(mlse_pkg::OP_READ_SORTED)) begin
      kind = mlse_pkg::KIND_SKIP;
    end else if (item_q.op == 3'(mlse_pkg::OP_CREATE) && item_q.size == 16'd0) begin
      code = mlse_pkg::ST_BAD_SIZE;
    end else if (!num_ok) begin
      code = mlse_pkg::ST_BAD_POS;
    end else if (item_q.op == 3'(mlse_pkg::OP_CREATE)) begin
      if (cur_exists) begin
        code = mlse_pkg::ST_EXISTS;
      end else if (item_q.size > 16'(MAX_DEPTH)) begin
        code = mlse_pkg::ST_NO_MEM;
      end
    end else if (!cur_exists) begin
      code = mlse_pkg::ST_NONE;
    end else begin
      case (item_q.op)
        3'(mlse_pkg::OP_APPEND): begin
          if (cnt >= cap) code = mlse_pkg::ST_FULL;
        end
        3'(mlse_pkg::OP_POP): begin
          if (cnt == '0) code = mlse_pkg::ST_EMPTY;
        end
        3'(mlse_pkg::OP_REMOVE): begin
          if (cnt == '0) code = mlse_pkg::ST_EMPTY;
          else kind = mlse_pkg::KIND_REMOVE;
        end
        3'(mlse_pkg::OP_READ): begin
          if (cnt != '0) kind = mlse_pkg::KIND_READ;
        end
        default: begin
          if (cnt != '0) kind = mlse_pkg::KIND_SORT;
        end
      endcase
    end
  end

  assign idx_last  = (CW'(idx_q) + CW'(1)) == cnt;
  assign pass_last = (CW'(pass_q) + CW'(1)) == cnt;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign commit_ok = cmd_i.commit && (code == mlse_pkg::ST_OK);

  assign sts_o.kind      = kind;
  assign sts_o.code      = code;
  assign sts_o.idx_last  = idx_last;
  assign sts_o.pass_last = pass_last;
  assign sts_o.match     = (mem_q == item_q.value);
  assign sts_o.out_free  = out_free;

  // The next sorted word is the smallest (value, index) above the last one sent.
  assign cand_gt = !have_prev_q || (mem_q > prev_v_q) ||
                   ((mem_q == prev_v_q) && (idx_q > prev_i_q));
  assign cand_lt = !found_q || (mem_q < best_v_q);

  // Memory write port: append or shift down by one.
  assign wr_en   = (commit_ok && item_q.op == 3'(mlse_pkg::OP_APPEND)) || cmd_i.shift_wr;
  assign wr_addr = cmd_i.shift_wr ? sh_addr : app_addr;
  assign wr_data = cmd_i.shift_wr ? mem_q : item_q.value;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.mem_rd) mem_q <= mem[rd_addr];
  end

  // Held input word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= in_word_i;
  end

  // List tables.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_LISTS; k++) begin
        exists_q[k] <= 1'b0;
        cap_q[k]    <= '0;
        fill_q[k]   <= '0;
      end
    end else if (commit_ok) begin
      case (item_q.op)
        3'(mlse_pkg::OP_CREATE): begin
          exists_q[li] <= 1'b1;
          cap_q[li]    <= CW'(item_q.size);
          fill_q[li]   <= '0;
        end
        3'(mlse_pkg::OP_APPEND): fill_q[li] <= cnt + CW'(1);
        3'(mlse_pkg::OP_POP):    fill_q[li] <= cnt - CW'(1);
        default: ;
      endcase
    end else if (cmd_i.dec_fill) begin
      fill_q[li] <= cnt - CW'(1);
    end
  end

  // Walk counters and sort tracking flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pass_q      <= '0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + IW'(1);
      if (cmd_i.pass_clr) begin
        pass_q      <= '0;
        have_prev_q <= 1'b0;
      end else begin
        if (cmd_i.pass_inc) pass_q <= pass_q + IW'(1);
        if (cmd_i.prev_upd) have_prev_q <= 1'b1;
      end
      if (cmd_i.best_clr) found_q <= 1'b0;
      else if (cmd_i.best_eval && cand_gt && cand_lt) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.best_eval && cand_gt && cand_lt) best_v_q <= mem_q;
    if (cmd_i.prev_upd) begin
      prev_v_q <= best_v_q;
      prev_i_q <= best_i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.best_eval && cand_gt && cand_lt) best_i_q <= idx_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != mlse_pkg::EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.emit)
      mlse_pkg::EMIT_CODE: begin
        out_q.status   <= 4'(cmd_i.code);
        out_q.data     <= '0;
        out_q.has_data <= 1'b0;
        out_q.last     <= 1'b1;
      end
      mlse_pkg::EMIT_ELEM: begin
        out_q.status   <= 4'(mlse_pkg::ST_OK);
        out_q.data     <= mem_q;
        out_q.has_data <= 1'b1;
        out_q.last     <= idx_last;
      end
      mlse_pkg::EMIT_BEST: begin
        out_q.status   <= 4'(mlse_pkg::ST_OK);
        out_q.data     <= best_v_q;
        out_q.has_data <= 1'b1;
        out_q.last     <= pass_last;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

[src/mlse_ctrl.sv]
// Controller: state machine that sequences checks, searches, shifts and readouts.
`default_nettype none

module mlse_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  mlse_pkg::sts_t  sts_i,
  output mlse_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RM_RD,
    S_RM_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RD_RD,
    S_RD_OUT,
    S_SR_RD,
    S_SR_CMP,
    S_SR_OUT,
    S_EMIT
  } state_e;

  state_e        state_q, state_d;
  mlse_pkg::st_e res_q, res_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts_i.kind)
          mlse_pkg::KIND_SINGLE: begin
            if (sts_i.out_free) begin
              cmd_o.commit = 1'b1;
              cmd_o.emit   = mlse_pkg::EMIT_CODE;
              cmd_o.code   = sts_i.code;
              state_d      = S_IDLE;
            end
          end
          mlse_pkg::KIND_REMOVE: begin
            cmd_o.idx_clr = 1'b1;
            state_d       = S_RM_RD;
          end
          mlse_pkg::KIND_READ: begin
            cmd_o.idx_clr = 1'b1;
            state_d       = S_RD_RD;
          end
          mlse_pkg::KIND_SORT: begin
            cmd_o.idx_clr  = 1'b1;
            cmd_o.pass_clr = 1'b1;
            cmd_o.best_clr = 1'b1;
            state_d        = S_SR_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RM_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_RM_CMP;
      end
      S_RM_CMP: begin
        if (sts_i.match) begin
          if (sts_i.idx_last) begin
            cmd_o.dec_fill = 1'b1;
            res_d          = mlse_pkg::ST_OK;
            state_d        = S_EMIT;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SH_RD;
          end
        end else if (sts_i.idx_last) begin
          res_d   = mlse_pkg::ST_NOT_FOUND;
          state_d = S_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RM_RD;
        end
      end
      S_SH_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.dec_fill = 1'b1;
          res_d          = mlse_pkg::ST_OK;
          state_d        = S_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SH_RD;
        end
      end
      S_RD_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = mlse_pkg::EMIT_ELEM;
          if (sts_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD_RD;
          end
        end
      end
      S_SR_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_SR_CMP;
      end
      S_SR_CMP: begin
        cmd_o.best_eval = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_SR_OUT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SR_RD;
        end
      end
      S_SR_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = mlse_pkg::EMIT_BEST;
          cmd_o.prev_upd = 1'b1;
          if (sts_i.pass_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.pass_inc = 1'b1;
            cmd_o.idx_clr  = 1'b1;
            cmd_o.best_clr = 1'b1;
            state_d        = S_SR_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = mlse_pkg::EMIT_CODE;
          cmd_o.code = res_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered result code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= mlse_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

`default_nettype wire

[src/multi_list_store_engine_core.sv]
// Top level of the multi-list store engine: controller, datapath and checks.
//
// The input channel takes one command word (op, list_number, value, size);
// the output channel returns result words (status, data, has_data, last).
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. One command is processed at a time: in_stall_o is high from
// the cycle after acceptance until the command has queued its last result.
// Create, append, pop and any command that fails a check end in the check state.
// Remove walks the list through the element memory's one read port, with a
// read and a compare state per entry for the search and a read and a write
// state per entry for closing the gap. Read reads and sends each entry in turn.
// Read sorted runs one full scan per output word, since the memory read port
// is the only path to the entries.
// Unknown ops are dropped in the check state with no result.
// The result sits in an output register, so a new command is accepted while
// a finished result still waits; a stalled receiver holds the engine only
// when the next result is ready. Reset empties all lists at once.
`default_nettype none

module multi_list_store_engine_core #(
  parameter int NUM_LISTS = 10,
  parameter int MAX_DEPTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  mlse_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output mlse_pkg::out_word_t out_word_o
);

  mlse_pkg::cmd_t cmd;
  mlse_pkg::sts_t sts;

  mlse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlse_dp #(
    .NUM_LISTS (NUM_LISTS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // A word without an element carries zero data and ends its command.
  a_nodata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.has_data |-> out_word_o.last && out_word_o.data == 32'sd0)
    else $error("result without element is not a final zero word");

  // Failing statuses never carry an element.
  a_err_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != 4'(mlse_pkg::ST_OK) |-> !out_word_o.has_data)
    else $error("error status with element data");

  // A result is only loaded while the output register is free.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit != mlse_pkg::EMIT_NONE |-> sts.out_free)
    else $error("result emitted over a stalled word");

endmodule

`default_nettype wire

[sim/multi_list_store_engine_core_tb.sv]
// Self-checking testbench for the multi-list store engine core.
`timescale 1ns / 100ps
`default_nettype none

module multi_list_store_engine_core_tb;

  localparam int NUM_LISTS = 10;
  localparam int MAX_DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  mlse_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b1;
  mlse_pkg::out_word_t out_word_o;

  multi_list_store_engine_core #(
    .NUM_LISTS(NUM_LISTS),
    .MAX_DEPTH(MAX_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: a private copy of every list.
  logic               pm_exists [NUM_LISTS];
  logic [4:0]         pm_cap    [NUM_LISTS];
  logic [4:0]         pm_fill   [NUM_LISTS];
  logic signed [31:0] pm_elem   [NUM_LISTS][MAX_DEPTH];

  mlse_pkg::out_word_t pending_results[$];
  int        error_count = 0;
  int        words_sent = 0;
  int        words_seen = 0;
  int        cycle_count = 0;
  bit        quiet_mode = 1'b0;
  bit        hold_off_req = 1'b0;

  function automatic mlse_pkg::out_word_t status_word(mlse_pkg::st_e code);
    mlse_pkg::out_word_t w;
    w = '0;
    w.status = code;
    w.last = 1'b1;
    return w;
  endfunction

  // Applies one command word to the model lists and queues its results.
  task automatic predict_command(mlse_pkg::in_word_t cmd);
    int li;
    int cnt;
    int hit;
    logic signed [31:0] buf_w [MAX_DEPTH];
    logic signed [31:0] t;
    mlse_pkg::out_word_t w;
    li = cmd.list_number - 1;
    hit = -1;
    if (cmd.op > mlse_pkg::OP_READ_SORTED) return;
    if (cmd.op == mlse_pkg::OP_CREATE && cmd.size < 1) begin
      pending_results.push_back(status_word(mlse_pkg::ST_BAD_SIZE));
      return;
    end
    if (cmd.list_number < 1 || cmd.list_number > NUM_LISTS) begin
      pending_results.push_back(status_word(mlse_pkg::ST_BAD_POS));
      return;
    end
    if (cmd.op == mlse_pkg::OP_CREATE) begin
      if (pm_exists[li]) pending_results.push_back(status_word(mlse_pkg::ST_EXISTS));
      else if (cmd.size > MAX_DEPTH)
        pending_results.push_back(status_word(mlse_pkg::ST_NO_MEM));
      else begin
        pm_exists[li] = 1'b1;
        pm_cap[li] = cmd.size[4:0];
        pm_fill[li] = '0;
        pending_results.push_back(status_word(mlse_pkg::ST_OK));
      end
      return;
    end
    if (!pm_exists[li]) begin
      pending_results.push_back(status_word(mlse_pkg::ST_NONE));
      return;
    end
    cnt = pm_fill[li];
    case (cmd.op)
      mlse_pkg::OP_APPEND: begin
        if (cnt >= pm_cap[li]) pending_results.push_back(status_word(mlse_pkg::ST_FULL));
        else begin
          pm_elem[li][cnt] = cmd.value;
          pm_fill[li] = 5'(cnt + 1);
          pending_results.push_back(status_word(mlse_pkg::ST_OK));
        end
      end
      mlse_pkg::OP_POP: begin
        if (cnt == 0) pending_results.push_back(status_word(mlse_pkg::ST_EMPTY));
        else begin
          pm_fill[li] = 5'(cnt - 1);
          pending_results.push_back(status_word(mlse_pkg::ST_OK));
        end
      end
      mlse_pkg::OP_REMOVE: begin
        if (cnt == 0) pending_results.push_back(status_word(mlse_pkg::ST_EMPTY));
        else begin
          for (int i = 0; i < cnt; i++)
            if (hit < 0 && pm_elem[li][i] == cmd.value) hit = i;
          if (hit < 0) pending_results.push_back(status_word(mlse_pkg::ST_NOT_FOUND));
          else begin
            for (int i = hit; i + 1 < cnt; i++) pm_elem[li][i] = pm_elem[li][i + 1];
            pm_fill[li] = 5'(cnt - 1);
            pending_results.push_back(status_word(mlse_pkg::ST_OK));
          end
        end
      end
      default: begin
        if (cnt == 0) pending_results.push_back(status_word(mlse_pkg::ST_OK));
        else begin
          for (int i = 0; i < cnt; i++) buf_w[i] = pm_elem[li][i];
          // Insertion sort on signed words for the sorted readout.
          if (cmd.op == mlse_pkg::OP_READ_SORTED)
            for (int i = 1; i < cnt; i++)
              for (int j = i; j > 0 && buf_w[j] < buf_w[j - 1]; j--) begin
                t = buf_w[j];
                buf_w[j] = buf_w[j - 1];
                buf_w[j - 1] = t;
              end
          for (int i = 0; i < cnt; i++) begin
            w.status = mlse_pkg::ST_OK;
            w.data = buf_w[i];
            w.has_data = 1'b1;
            w.last = (i + 1 == cnt);
            pending_results.push_back(w);
          end
        end
      end
    endcase
  endtask

  // Compares each accepted result word with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, actual %p", $time, out_word_o);
        error_count++;
      end else begin
        mlse_pkg::out_word_t e;
        e = pending_results.pop_front();
        if (out_word_o.status !== e.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, e.status, out_word_o.status);
          error_count++;
        end
        if (out_word_o.data !== e.data) begin
          $display("%0t: data mismatch, expected %0d actual %0d",
                   $time, e.data, out_word_o.data);
          error_count++;
        end
        if (out_word_o.has_data !== e.has_data) begin
          $display("%0t: has_data mismatch, expected %0b actual %0b",
                   $time, e.has_data, out_word_o.has_data);
          error_count++;
        end
        if (out_word_o.last !== e.last) begin
          $display("%0t: last mismatch, expected %0b actual %0b",
                   $time, e.last, out_word_o.last);
          error_count++;
        end
      end
    end
  end

  // Receiver stall: random idling, a quiet stretch, and one long hold-off.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        for (hold = 0; hold < 300; hold++) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      out_stall_i <= quiet_mode ? 1'b0 : ($urandom_range(0, 99) < 28);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one command word and updates the prediction on acceptance.
  // Valid stays high after acceptance until the next call or a drain drives it.
  task automatic send_word(mlse_pkg::in_word_t cmd);
    while (!quiet_mode && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_command(cmd);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic mlse_pkg::in_word_t make_word(logic [2:0] op, logic [3:0] num,
                                                   logic [31:0] val, logic [15:0] sz);
    mlse_pkg::in_word_t w;
    w.op = op;
    w.list_number = num;
    w.value = val;
    w.size = sz;
    return w;
  endfunction

  // Directed table: command word, flag for a typed-in status, that status.
  typedef struct {
    mlse_pkg::in_word_t cmd;
    bit                 typed;
    mlse_pkg::st_e      code;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic mlse_pkg::in_word_t random_word(int target);
    mlse_pkg::in_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.list_number = (pick < 92) ? target[3:0] : 4'($urandom_range(0, 15));
    w.value = (pick % 3 == 0) ? 32'($urandom_range(0, 7) - 4) : $urandom;
    w.size = (pick < 8) ? 16'($urandom) : 16'($urandom_range(1, MAX_DEPTH));
    pick = $urandom_range(0, 99);
    if (pick < 45) w.op = mlse_pkg::OP_APPEND;
    else if (pick < 55) w.op = mlse_pkg::OP_POP;
    else if (pick < 70) w.op = mlse_pkg::OP_REMOVE;
    else if (pick < 80) w.op = mlse_pkg::OP_READ;
    else if (pick < 90) w.op = mlse_pkg::OP_READ_SORTED;
    else if (pick < 96) w.op = mlse_pkg::OP_CREATE;
    else w.op = 3'($urandom_range(6, 7));
    // Remove mostly picks a stored value so that gaps get closed.
    if (w.op == mlse_pkg::OP_REMOVE && target >= 1 && target <= NUM_LISTS &&
        pm_fill[target - 1] != 0 && $urandom_range(0, 3) != 0)
      w.value = pm_elem[target - 1][$urandom_range(0, pm_fill[target - 1] - 1)];
    return w;
  endfunction

  initial begin
    int target;
    for (int i = 0; i < NUM_LISTS; i++) begin
      pm_exists[i] = 1'b0;
      pm_cap[i] = '0;
      pm_fill[i] = '0;
    end
    dir_rows.push_back('{make_word(mlse_pkg::OP_READ, 4'd1, 32'd0, 16'd0),
                         1'b1, mlse_pkg::ST_NONE});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd0, 32'd0, 16'd0),
                         1'b1, mlse_pkg::ST_BAD_SIZE});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd0, 32'd0, 16'd4),
                         1'b1, mlse_pkg::ST_BAD_POS});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd15, 32'd0, 16'd4),
                         1'b1, mlse_pkg::ST_BAD_POS});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd11, 32'd0, 16'd4),
                         1'b1, mlse_pkg::ST_BAD_POS});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd1, 32'd0, 16'd17),
                         1'b1, mlse_pkg::ST_NO_MEM});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd1, 32'd0, 16'hFFFF),
                         1'b1, mlse_pkg::ST_NO_MEM});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd1, 32'd0, 16'd2),
                         1'b1, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd1, 32'd0, 16'd2),
                         1'b1, mlse_pkg::ST_EXISTS});
    dir_rows.push_back('{make_word(mlse_pkg::OP_POP, 4'd1, 32'd0, 16'd0),
                         1'b1, mlse_pkg::ST_EMPTY});
    dir_rows.push_back('{make_word(mlse_pkg::OP_REMOVE, 4'd1, 32'd0, 16'd0),
                         1'b1, mlse_pkg::ST_EMPTY});
    dir_rows.push_back('{make_word(mlse_pkg::OP_READ, 4'd1, 32'd0, 16'd0),
                         1'b1, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_APPEND, 4'd1, 32'h7FFFFFFF, 16'd0),
                         1'b1, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_APPEND, 4'd1, 32'h80000000, 16'd0),
                         1'b1, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_APPEND, 4'd1, 32'd5, 16'd0),
                         1'b1, mlse_pkg::ST_FULL});
    dir_rows.push_back('{make_word(mlse_pkg::OP_READ, 4'd1, 32'd0, 16'd0),
                         1'b0, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_READ_SORTED, 4'd1, 32'd0, 16'd0),
                         1'b0, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_REMOVE, 4'd1, 32'd3, 16'd0),
                         1'b1, mlse_pkg::ST_NOT_FOUND});
    dir_rows.push_back('{make_word(mlse_pkg::OP_REMOVE, 4'd1, 32'h7FFFFFFF, 16'd0),
                         1'b1, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(3'd6, 4'd1, 32'hFFFFFFFF, 16'hFFFF),
                         1'b0, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(3'd7, 4'd10, 32'd0, 16'd0),
                         1'b0, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_READ, 4'd1, 32'd0, 16'd0),
                         1'b0, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_POP, 4'd1, 32'd0, 16'd0),
                         1'b1, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_CREATE, 4'd10, 32'd0, 16'd16),
                         1'b1, mlse_pkg::ST_OK});
    dir_rows.push_back('{make_word(mlse_pkg::OP_APPEND, 4'd12, 32'd0, 16'd0),
                         1'b1, mlse_pkg::ST_BAD_POS});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: typed statuses are checked against the predictor too.
    foreach (dir_rows[r]) begin
      int before_n;
      before_n = pending_results.size();
      send_word(dir_rows[r].cmd);
      if (dir_rows[r].typed && pending_results.size() > before_n &&
          pending_results[before_n].status != dir_rows[r].code) begin
        $display("%0t: directed row %0d, expected status %0d predicted %0d",
                 $time, r, dir_rows[r].code, pending_results[before_n].status);
        error_count++;
      end
    end
    wait_drained();

    // Create lists 2 to 9 with mixed capacities; list 2 gets size 1, list 10 has 16 already.
    for (int n = 2; n <= NUM_LISTS - 1; n++)
      send_word(make_word(mlse_pkg::OP_CREATE, 4'(n), $urandom,
                          (n == 2) ? 16'd1 : 16'($urandom_range(1, MAX_DEPTH))));

    // Random part; list 10 holds up to 16 entries and fills fast.
    for (int k = 0; k < 250; k++) begin
      if (k == 60) hold_off_req = 1'b1;
      if (k == 120) wait_drained();
      quiet_mode = (k >= 160 && k < 200);
      target = ($urandom_range(0, 2) == 0) ? NUM_LISTS : $urandom_range(1, NUM_LISTS);
      send_word(random_word(target));
    end
    quiet_mode = 1'b0;

    wait_drained();
    repeat (600) @(negedge clk_i);
    $display("Sent %0d command words, checked %0d result words", words_sent, words_seen);
    $display("Covered all ops, check order errors, full and empty lists, sorted reads");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
